// ===== sv/pcmp_pkg.sv =====
// Package for the predictor compressor.
// Holds the shared byte type, the fixed constants of the group format and the hash multiplier.
// No dependencies.
package pcmp_pkg;

   // One stream byte.
   typedef logic [7:0] byte_type;

   // Bytes in one group, and the bits that address a place in it.
   localparam int GROUP_SIZE = 8;
   localparam int POS_BITS   = 3;

   // Emission index runs from the flag byte (0) to the last group place.
   localparam int EMIT_BITS  = 4;

   // Multiplier of the running context hash.
   localparam int HASH_MULT  = 160;

endpackage

// ===== sv/pcmp_guess_ram.sv =====
// Guess table storage for the predictor compressor.
// One write port and one read port, with registered read data.
// Depends on pcmp_pkg.
module pcmp_guess_ram #(
   parameter int ADDR_BITS = 18
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [ADDR_BITS-1:0]     wr_addr,
   input  pcmp_pkg::byte_type       wr_data,
   input  logic                     rd_en,
   input  logic [ADDR_BITS-1:0]     rd_addr,
   output pcmp_pkg::byte_type       rd_data
);
   import pcmp_pkg::*;

   localparam int DEPTH = 2 ** ADDR_BITS;

   byte_type mem_ff [DEPTH];
   byte_type rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port with the data registered.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/predictor_compressor_top.sv =====
// Top level of the predictor compressor: sequencer, hash, group state, output register.
// Depends on pcmp_pkg and pcmp_guess_ram.
//
// Channel | Direction | Handshake            | Payload
// req     | in        | req_valid/req_stall  | req_mode, req_data_byte
// rsp     | out       | rsp_valid/rsp_stall  | rsp_out_byte, rsp_last
//
// A pushed byte is handled as the guess table read issued on acceptance, then the
// compare and write-back, both through the single port pair of the table.
// A flush pad byte is handled as a read, then a compare, repeated until the group closes.
// Closing a group emits the flag byte, then steps through the group places up to the last
// missed one, and waits while rsp_stall holds the output register.
// After reset the table is cleared one entry a cycle, with req_stall high.
// Reset is synchronous and active high.
module predictor_compressor_top #(
   parameter int HASH_BITS = 18
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_mode,
   input  pcmp_pkg::byte_type   req_data_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output pcmp_pkg::byte_type   rsp_out_byte,
   output logic                 rsp_last
);
   import pcmp_pkg::*;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_READ  = 3'd2;
   localparam logic [2:0] ST_CMP   = 3'd3;
   localparam logic [2:0] ST_EMIT  = 3'd4;

   localparam int PROD_BITS = HASH_BITS + 8;

   logic [2:0]            state_ff, state_in;
   logic [HASH_BITS-1:0]  clr_ff, clr_in;
   logic [HASH_BITS-1:0]  hash_ff, hash_in;
   logic [GROUP_SIZE-1:0] flags_ff, flags_in;
   logic [POS_BITS-1:0]   pos_ff, pos_in;
   logic [EMIT_BITS-1:0]  idx_ff, idx_in;
   logic                  mode_ff;
   byte_type              byte_ff;
   byte_type              miss_buf_ff [GROUP_SIZE];
   logic                  rsp_valid_ff, rsp_valid_in;
   byte_type              rsp_out_byte_ff;
   logic                  rsp_last_ff;

   logic                  req_accept;
   logic                  ram_wr_en;
   logic [HASH_BITS-1:0]  ram_wr_addr;
   byte_type              ram_wr_data;
   logic                  ram_rd_en;
   byte_type              ram_rd_data;
   logic                  is_miss;
   logic [PROD_BITS-1:0]  hash_prod;
   logic [HASH_BITS-1:0]  hash_next;
   logic                  out_free;
   logic [POS_BITS-1:0]   emit_pos;
   logic [GROUP_SIZE-1:0] miss_mask;
   logic                  last_miss;
   logic                  load_out;
   byte_type              load_byte;
   logic                  load_last;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   // Guess table: cleared after reset, read at the running hash.
   pcmp_guess_ram #(
      .ADDR_BITS (HASH_BITS)
   ) u_guess_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (hash_ff),
      .rd_data (ram_rd_data)
   );

   assign is_miss     = (ram_rd_data != byte_ff);
   assign ram_rd_en   = req_accept || (state_ff == ST_READ);
   assign ram_wr_en   = (state_ff == ST_CLEAR) || ((state_ff == ST_CMP) && is_miss);
   assign ram_wr_addr = (state_ff == ST_CLEAR) ? clr_ff : hash_ff;
   assign ram_wr_data = (state_ff == ST_CLEAR) ? '0 : byte_ff;

   // Next context hash: hash * 160 xor byte, kept to the table width.
   assign hash_prod = {8'b0, hash_ff} * PROD_BITS'(HASH_MULT);
   assign hash_next = hash_prod[HASH_BITS-1:0] ^ {{(HASH_BITS-8){1'b0}}, byte_ff};

   // Emission selection: index 0 is the flag byte, index i is group place i-1.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign emit_pos  = idx_ff[POS_BITS-1:0] - POS_BITS'(1);
   assign miss_mask = ~flags_ff;
   assign last_miss = ((miss_mask >> idx_ff) == '0);

   always_comb begin
      load_out  = 1'b0;
      load_byte = flags_ff;
      load_last = 1'b0;
      if (state_ff == ST_EMIT && out_free) begin
         if (idx_ff == '0) begin
            load_out  = 1'b1;
            load_byte = flags_ff;
            load_last = (flags_ff == '1);
         end else if (!flags_ff[emit_pos]) begin
            load_out  = 1'b1;
            load_byte = miss_buf_ff[emit_pos];
            load_last = last_miss;
         end
      end
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      hash_in  = hash_ff;
      flags_in = flags_ff;
      pos_in   = pos_ff;
      idx_in   = idx_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + HASH_BITS'(1);
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept && !(req_mode && pos_ff == '0)) begin
               state_in = ST_CMP;
            end
         end
         ST_READ: begin
            state_in = ST_CMP;
         end
         ST_CMP: begin
            hash_in = hash_next;
            if (!is_miss) begin
               flags_in[pos_ff] = 1'b1;
            end
            pos_in = pos_ff + POS_BITS'(1);
            if (pos_ff == '1) begin
               idx_in   = '0;
               state_in = ST_EMIT;
            end else if (mode_ff) begin
               state_in = ST_READ;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (idx_ff != '0 && flags_ff[emit_pos]) begin
               idx_in = idx_ff + EMIT_BITS'(1);
            end else if (load_out) begin
               idx_in = idx_ff + EMIT_BITS'(1);
               if (load_last) begin
                  flags_in = '0;
                  pos_in   = '0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Output register valid flag.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         hash_ff      <= '0;
         flags_ff     <= '0;
         pos_ff       <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         hash_ff      <= hash_in;
         flags_ff     <= flags_in;
         pos_ff       <= pos_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: the accepted transaction, missed bytes and the output byte.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         mode_ff <= req_mode;
         byte_ff <= req_data_byte;
      end
      if (state_ff == ST_CMP && is_miss) begin
         miss_buf_ff[pos_ff] <= byte_ff;
      end
      if (load_out) begin
         rsp_out_byte_ff <= load_byte;
         rsp_last_ff     <= load_last;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_out_byte_ff;
   assign rsp_last     = rsp_last_ff;

`ifndef SYNTHESIS
   // A result only appears after the sequencer has been emitting.
   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_EMIT))
      else $error("result raised outside group emission");

   // The emission index never runs past the last group place.
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (idx_ff <= EMIT_BITS'(GROUP_SIZE)))
      else $error("emission index out of range");

   // A flush with no open group leaves the block idle and the group empty.
   a_empty_flush: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_mode && pos_ff == '0) |=> (state_ff == ST_IDLE && pos_ff == '0))
      else $error("flush of an empty group changed state");

   // Loading the final byte of a run closes the group.
   a_group_close: assert property (@(posedge clock) disable iff (reset)
      (load_out && load_last) |=> (state_ff == ST_IDLE && pos_ff == '0 && flags_ff == '0))
      else $error("group not closed after its final byte");
`endif

endmodule
